// ===== hdl/lgpg_pkg.sv =====
`timescale 1ns / 1ps
package lgpg_pkg;
	localparam int unsigned NEUTRAL = 11520;
	localparam int unsigned HIP_LIM = 23040;

	typedef enum logic [2:0] {
		CFG_DURATION = 3'd0,
		CFG_START    = 3'd1,
		CFG_OFF0     = 3'd2,
		CFG_OFF1     = 3'd3,
		CFG_OFF2     = 3'd4,
		CFG_OFF3     = 3'd5,
		CFG_STEP     = 3'd6,
		CFG_SPEED    = 3'd7
	} cfg_idx_t;

	// handshake between the sequencer and the bit-serial divider
	typedef struct packed {
		logic        start;
		logic [47:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [47:0] quotient;
		logic [15:0] remainder;
	} div_rsp_t;

	// Q15 half sine, 6-term series of cos(pi*t), t = i/D - 1/2, in Q30
	function automatic logic [15:0] sine_entry(input int unsigned i, input int unsigned d);
		longint n;
		longint unsigned num, p1, p2, p3, p4, p5;
		longint unsigned num_sh, den, rem;
		longint s;
		n = 2 * longint'(i) - longint'(d);
		num = longint'(n * n);
		den = 4 * longint'(d) * longint'(d);
		num_sh = num << 30;
		// long division by compare and subtract
		p1 = 0;
		rem = 0;
		for (int b = 63; b >= 0; b--) begin
			rem = (rem << 1) | ((num_sh >> b) & 64'd1);
			if (rem >= den) begin
				rem = rem - den;
				p1 = p1 | (64'd1 << b);
			end
		end
		p2 = (p1 * p1) >> 30;
		p3 = (p2 * p1) >> 30;
		p4 = (p3 * p1) >> 30;
		p5 = (p4 * p1) >> 30;
		s = 64'sd1073741824;
		s -= longint'((64'd5298703516 * p1) >> 30);
		s += longint'((64'd4358008960 * p2) >> 30);
		s -= longint'((64'd1433727481 * p3) >> 30);
		s += longint'((64'd252684341 * p4) >> 30);
		s -= longint'((64'd27709939 * p5) >> 30);
		if (s < 0) s = 0;
		if (s > 64'sd1073741824) s = 64'sd1073741824;
		sine_entry = 16'((unsigned'(s) + 64'd16384) >> 15);
	endfunction
endpackage

// ===== hdl/lgpg_div.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module lgpg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lgpg_pkg::div_req_t req,
	output lgpg_pkg::div_rsp_t rsp
);
	logic [47:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] shifted;
	logic [17:0] diff;

	assign shifted = {rem_q, quo_q[47]};
	assign diff = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd47;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				rem_q <= diff[15:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted[15:0];
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q, quotient: quo_q, remainder: rem_q};

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> req.divisor != 16'd0) else $error("zero divisor");
endmodule

// ===== hdl/lgpg_mul.sv =====
`timescale 1ns / 1ps
// shift-add multiplier, one multiplier bit per cycle, signed a by unsigned b
module lgpg_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [17:0] a,
	input  logic        [17:0] b,
	output logic               done,
	output logic signed [36:0] prod
);
	logic signed [36:0] acc_q;
	logic signed [36:0] mcand_q;
	logic [17:0] mplier_q;
	logic [4:0]  cnt_q;
	logic        busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd17;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mcand_q <= 37'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign prod = acc_q;
endmodule

// ===== hdl/legged_gait_phase_generator.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      time_ms, target_forward, target_turn; tuser moving
// m_axis    out  m_axis_tvalid/tready      leg, hip, shoulder, knee, swing; tlast last
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
// a moving tick runs two 48-bit bit-serial divisions, then per leg the phase
// and sine steps, the serial hip multiply and one output word
// ticks are handled one at a time; not-moving ticks are accepted in idle and give no words
// output register holds a word until taken; the sequencer waits on it
// arst_n clears control state and restores register defaults, no clearing pass
module legged_gait_phase_generator #(
	parameter int LEG_COUNT = 4,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // time_ms[31:0], target_forward[46:32], target_turn[61:47]
	input  logic        s_axis_tuser,  // moving
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // leg[1:0], hip[17:2], shoulder[32:18], knee[47:33], swing[48]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int AW = $clog2(SINE_TABLE_DEPTH);
	localparam int LW = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
	localparam logic [31:0] NEUTRAL_C = 32'(lgpg_pkg::NEUTRAL);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DIV1  = 7'b0000010,
		S_DIV2  = 7'b0000100,
		S_LEG   = 7'b0001000,
		S_SINE  = 7'b0010000,
		S_HIP   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [15:0] dur_q, off_q [4], step_q;
	logic [31:0] start_q;
	logic [13:0] max_q;
	logic signed [15:0] cur_f_q, cur_t_q, tgt_f_q, tgt_t_q;
	logic [31:0] now_q;
	logic [15:0] prog_q, ph_q;
	logic [LW-1:0] leg_q;
	logic signed [15:0] sh_q, kn_q, toff_q;
	logic turning_q;
	logic [15:0] sine_tab [SINE_TABLE_DEPTH];

	lgpg_pkg::div_req_t dreq;
	lgpg_pkg::div_rsp_t drsp;
	logic mstart, mdone;
	logic signed [17:0] ma;
	logic [17:0] mb;
	logic signed [36:0] mprod;

	lgpg_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	lgpg_mul u_mul (.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb),
		.done(mdone), .prod(mprod));

	always_comb begin
		for (int i = 0; i < SINE_TABLE_DEPTH; i++)
			sine_tab[i] = lgpg_pkg::sine_entry(i, SINE_TABLE_DEPTH);
	end

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);

	// leg phase math, offset register picked by leg mod 4
	logic [1:0] leg_lo;
	logic [15:0] ph_next;
	logic sw;
	logic [15:0] sp;
	logic signed [17:0] m_val;
	logic [AW-1:0] sidx;
	logic [AW+15:0] idx_full;
	assign leg_lo = 2'(leg_q);
	assign ph_next = prog_q + off_q[leg_lo];
	assign sw = ph_q[15];
	assign sp = {ph_q[14:0], 1'b0};
	assign m_val = sw ? (18'(sp) - 18'sd32768) : (18'sd32768 - 18'(sp));
	assign idx_full = (AW+16)'(sp) * (AW+16)'(SINE_TABLE_DEPTH);
	assign sidx = idx_full[AW+15:16];

	function automatic logic signed [15:0] clampt(input logic signed [14:0] t,
		input logic [13:0] m);
		logic signed [15:0] tt, mm;
		tt = 16'(t);
		mm = {2'b00, m};
		if (tt > mm) clampt = mm;
		else if (tt < -mm) clampt = -mm;
		else clampt = tt;
	endfunction

	function automatic logic signed [15:0] smooth(input logic signed [15:0] c,
		input logic signed [15:0] t);
		logic signed [16:0] d;
		logic [16:0] a;
		logic [15:0] q;
		d = 17'(t) - 17'(c);
		a = d[16] ? 17'(-d) : 17'(d);
		// divide by ten through reciprocal, then one correction step
		q = 16'(((32'(a) + 32'd5) * 32'd6554) >> 16);
		if ((q * 10) > (a + 5)) q = q - 16'd1;
		smooth = d[16] ? c - q : c + q;
	endfunction

	// hip value from product of v and m (m times 5 folded in by multiplier b)
	logic signed [36:0] hp;
	logic [36:0] hmag;
	logic signed [19:0] hr;
	logic signed [19:0] hsum;
	logic signed [15:0] hip;
	assign hp = mprod;
	assign hmag = hp[36] ? 37'(-hp) : 37'(hp);
	assign hr = hp[36] ? -20'((hmag + 37'd262144) >> 19) : 20'((hmag + 37'd262144) >> 19);
	assign hsum = !turning_q ? hr : (leg_q[0] ? hr - 20'(toff_q) : hr + 20'(toff_q));
	assign hip = (hsum > 20'sd23040) ? 16'sd23040 :
		(hsum < -20'sd23040) ? -16'sd23040 : hsum[15:0];

	logic [31:0] sprod;
	assign sprod = 32'(step_q) * 32'(sine_tab[sidx]);

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = '0;
		dreq.divisor = (dur_q == 16'd0) ? 16'd1 : dur_q;
		mstart = 1'b0;
		ma = 18'(cur_f_q);
		mb = 18'(m_val[17] ? -m_val : m_val) * 18'd5;
		unique case (state_q)
			S_IDLE: begin
				dreq.start = s_axis_tvalid && s_axis_tuser;
				dreq.dividend = {16'd0, s_axis_tdata[31:0] - start_q};
			end
			S_DIV1: if (drsp.done) begin
				dreq.start = 1'b1;
				dreq.dividend = {drsp.remainder, 32'd0} >> 16;
			end
			S_LEG: ;
			S_SINE: mstart = 1'b1;
			default: ;
		endcase
		if (m_val[17]) ma = -18'(cur_f_q);
	end

	logic [15:0] tabs;
	assign tabs = cur_t_q[15] ? 16'(-cur_t_q) : cur_t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dur_q <= 16'd2000; start_q <= '0;
			off_q[0] <= 16'd0; off_q[1] <= 16'd32768;
			off_q[2] <= 16'd32768; off_q[3] <= 16'd0;
			step_q <= 16'd7680; max_q <= 14'd4096;
			cur_f_q <= '0; cur_t_q <= '0;
			leg_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (lgpg_pkg::cfg_idx_t'(cfg_index))
					lgpg_pkg::CFG_DURATION: dur_q <= cfg_data[15:0];
					lgpg_pkg::CFG_START:    start_q <= cfg_data;
					lgpg_pkg::CFG_OFF0:     off_q[0] <= cfg_data[15:0];
					lgpg_pkg::CFG_OFF1:     off_q[1] <= cfg_data[15:0];
					lgpg_pkg::CFG_OFF2:     off_q[2] <= cfg_data[15:0];
					lgpg_pkg::CFG_OFF3:     off_q[3] <= cfg_data[15:0];
					lgpg_pkg::CFG_STEP:     step_q <= {2'b00, cfg_data[13:0]};
					lgpg_pkg::CFG_SPEED:    max_q <= cfg_data[13:0];
					default: ;
				endcase
			end
			if (state_q == S_OUT && (!m_axis_tvalid || m_axis_tready))
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tuser) begin
					tgt_f_q <= clampt(s_axis_tdata[46:32], max_q);
					tgt_t_q <= clampt(s_axis_tdata[61:47], max_q);
					turning_q <= tabs > 16'd40;
					toff_q <= 16'((cur_t_q[15] ? -((17'(tabs) * 15 + 16) >> 5)
						: ((17'(tabs) * 15 + 16) >> 5)));
					state_q <= S_DIV1;
				end
				S_DIV1: if (drsp.done) state_q <= S_DIV2;
				S_DIV2: if (drsp.done) begin
					prog_q <= drsp.quotient[15:0];
					leg_q <= '0;
					state_q <= S_LEG;
				end
				S_LEG: begin
					ph_q <= ph_next;
					state_q <= S_SINE;
				end
				S_SINE: begin
					if (sw && sp != 16'd0 || ph_q > 16'd32768 || ph_q == 16'd32768) begin
						sh_q <= 16'(NEUTRAL_C - 32'((sprod + 32'd32768) >> 16));
						kn_q <= 16'(NEUTRAL_C - 32'((sprod + 32'd65536) >> 17));
					end else begin
						sh_q <= 16'(NEUTRAL_C);
						kn_q <= 16'(NEUTRAL_C);
					end
					state_q <= S_HIP;
				end
				S_HIP: if (mdone) state_q <= S_OUT;
				S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
					m_axis_tdata <= {7'd0, ph_q > 16'd32768, kn_q[14:0], sh_q[14:0],
						hip, leg_lo};
					m_axis_tlast <= (32'(leg_q) == LEG_COUNT - 1);
					if (32'(leg_q) == LEG_COUNT - 1) begin
						cur_f_q <= smooth(cur_f_q, tgt_f_q);
						cur_t_q <= smooth(cur_t_q, tgt_t_q);
						state_q <= S_IDLE;
					end else begin
						leg_q <= leg_q + LW'(1);
						state_q <= S_LEG;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("output word dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !s_axis_tready) else $error("accept while busy");
	a_hip_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[17:2]) <= 16'sd23040 &&
		$signed(m_axis_tdata[17:2]) >= -16'sd23040)) else $error("hip out of range");
endmodule
